@@ rtl/chtr_pkg.sv @@
// chtr_pkg: shared constants, codes and controller/datapath interface types
// for the chained hash table with doubling rehash; no dependencies
package chtr_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int MAX_BUCKETS = 2048;

    localparam int ENT_W  = $clog2(MAX_ENTRIES);
    localparam int NODE_W = ENT_W + 1;
    localparam int BKT_W  = $clog2(MAX_BUCKETS);
    localparam int BCNT_W = BKT_W + 1;
    localparam int CNT_W  = ENT_W + 1;
    localparam int KEY_W  = 31;
    localparam int VAL_W  = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int INIT_W = 11;
    localparam int DCNT_W = $clog2(KEY_W);

    localparam logic [NODE_W-1:0] EMPTY_MARK = NODE_W'(MAX_ENTRIES);
    localparam logic [INIT_W-1:0] INIT_RESET = INIT_W'(16);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_ABSENT  = 2'd1;
    localparam logic [ST_W-1:0] ST_PRESENT = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_CLR_INIT,
        CMD_CLR,
        CMD_ACCEPT,
        CMD_DIV_STEP,
        CMD_HEAD_RD,
        CMD_HEAD_LD,
        CMD_NODE_RD,
        CMD_NODE_LD,
        CMD_DEL,
        CMD_SCAN_INIT,
        CMD_SCAN_RD,
        CMD_SCAN_NEXT,
        CMD_INS_WR,
        CMD_INS_LINK,
        CMD_RH_INIT,
        CMD_RH_CLR,
        CMD_RH_HEAD_RD,
        CMD_RH_HEAD_LD,
        CMD_RH_NODE_RD,
        CMD_RH_NODE_LD,
        CMD_RH_TAIL_RD,
        CMD_RH_TAIL_LD,
        CMD_RH_LINK,
        CMD_RH_NEXT_BKT,
        CMD_RH_FINISH,
        CMD_RESULT
    } dp_cmd_e_t;

    typedef struct packed {
        dp_cmd_e_t       cmd;
        logic [ST_W-1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic            cur_empty;
        logic            key_match;
        logic            used_bit;
        logic            div_last;
        logic            clr_last;
        logic            rb_last;
        logic            pairs_full;
        logic            need_grow;
        logic            can_grow;
        logic            out_busy;
        logic            found;
        logic [OP_W-1:0] op;
    } dp_status_t;

endpackage

@@ rtl/chained_hash_table_rehash.sv @@
// chained_hash_table_rehash: top level of the chained key/value hash table
// instantiates chtr_ctrl and chtr_dp; uses chtr_pkg
//
//  channel  ports               direction  transfer
//  s_       op, key, value      in         s_valid & s_ready
//  m_       found, status,      out        m_valid & m_ready
//           bucket_count, entry_count
//  cfg_     wr_data             in         cfg_wr_en
//
// one request at a time: a serial remainder, then a walk of the chain node
// by node; an insert then scans for the lowest free slot
// a rehash adds a sweep of the whole table plus a serial remainder for each
// stored pair and a visit to each old bucket
// after reset and after each config write a clearing pass over every bucket runs,
// during which s_ready stays low
// a result waiting on m_ready does not block the next transfer on s_
module chained_hash_table_rehash (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [chtr_pkg::INIT_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [chtr_pkg::OP_W-1:0]   s_op,
    input  logic [chtr_pkg::KEY_W-1:0]  s_key,
    input  logic [chtr_pkg::VAL_W-1:0]  s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_found,
    output logic [chtr_pkg::ST_W-1:0]   m_status,
    output logic [chtr_pkg::BCNT_W-1:0] m_bucket_count,
    output logic [chtr_pkg::CNT_W-1:0]  m_entry_count
);
    import chtr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    chtr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    chtr_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_wr_data    (cfg_wr_data),
        .cfg_wr_en      (cfg_wr_en),
        .s_op           (s_op),
        .s_key          (s_key),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_status       (m_status),
        .m_bucket_count (m_bucket_count),
        .m_entry_count  (m_entry_count)
    );

endmodule

@@ rtl/chtr_ram.sv @@
// chtr_ram: generic single-port ram, read-first, registered read data
// no dependencies
module chtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wr_data;
        end
        rd_data <= mem[addr];
    end

endmodule

@@ rtl/chtr_dp.sv @@
// chtr_dp: datapath of the hash table: entry and bucket memories, serial
// remainder unit, chain pointers and result registers; uses chtr_pkg, chtr_ram
module chtr_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  chtr_pkg::dp_cmd_t           cmd,
    output chtr_pkg::dp_status_t        sts,
    input  logic [chtr_pkg::INIT_W-1:0] cfg_wr_data,
    input  logic                        cfg_wr_en,
    input  logic [chtr_pkg::OP_W-1:0]   s_op,
    input  logic [chtr_pkg::KEY_W-1:0]  s_key,
    input  logic [chtr_pkg::VAL_W-1:0]  s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_found,
    output logic [chtr_pkg::ST_W-1:0]   m_status,
    output logic [chtr_pkg::BCNT_W-1:0] m_bucket_count,
    output logic [chtr_pkg::CNT_W-1:0]  m_entry_count
);
    import chtr_pkg::*;

    logic [INIT_W-1:0] init_reg;
    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [BCNT_W-1:0] bnow_reg;
    logic [BCNT_W-1:0] grown_reg;
    logic [CNT_W-1:0]  pairs_reg;
    logic              bank_reg;
    logic [KEY_W-1:0]  dvd_reg;
    logic [BCNT_W-1:0] dsr_reg;
    logic [BCNT_W-1:0] rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [BKT_W-1:0]  bucket_reg;
    logic [BKT_W-1:0]  clr_reg;
    logic [BKT_W-1:0]  rb_reg;
    logic [ENT_W-1:0]  scan_reg;
    logic [NODE_W-1:0] cur_reg;
    logic [NODE_W-1:0] prev_reg;
    logic [NODE_W-1:0] nxt_reg;
    logic [NODE_W-1:0] tl_reg;
    logic              found_reg;
    logic              m_valid_reg;
    logic              m_found_reg;
    logic [ST_W-1:0]   m_status_reg;
    logic [BCNT_W-1:0] m_bcnt_reg;
    logic [CNT_W-1:0]  m_ecnt_reg;

    logic [BCNT_W:0]   rem_sh;
    logic [BCNT_W:0]   rem_sub;
    logic [BCNT_W:0]   dbl;
    logic [BCNT_W-1:0] grown;
    logic [BCNT_W-1:0] init_clamped;
    logic [BKT_W-1:0]  rem_bkt;

    logic              key_we, next_we, used_we, head_we, tail_we;
    logic [ENT_W-1:0]  key_addr, next_addr, used_addr;
    logic [BKT_W:0]    head_addr;
    logic [BKT_W-1:0]  tail_addr;
    logic [NODE_W-1:0] next_wd, head_wd, tail_wd;
    logic              used_wd;
    logic [KEY_W-1:0]  key_rd;
    logic [NODE_W-1:0] next_rd, head_rd, tail_rd;
    logic              used_rd;

    // serial remainder step
    assign rem_sh  = {rem_reg, dvd_reg[KEY_W-1]};
    assign rem_sub = (rem_sh >= {1'b0, dsr_reg}) ? rem_sh - {1'b0, dsr_reg} : rem_sh;
    assign rem_bkt = rem_reg[BKT_W-1:0];

    assign dbl   = {bnow_reg, 1'b0};
    assign grown = (dbl > (BCNT_W + 1)'(MAX_BUCKETS)) ? BCNT_W'(MAX_BUCKETS)
                                                      : dbl[BCNT_W-1:0];

    always_comb begin
        if (init_reg == '0) begin
            init_clamped = BCNT_W'(1);
        end else if (BCNT_W'(init_reg) > BCNT_W'(MAX_BUCKETS)) begin
            init_clamped = BCNT_W'(MAX_BUCKETS);
        end else begin
            init_clamped = BCNT_W'(init_reg);
        end
    end

    always_comb begin
        key_we    = 1'b0;
        next_we   = 1'b0;
        used_we   = 1'b0;
        head_we   = 1'b0;
        tail_we   = 1'b0;
        key_addr  = cur_reg[ENT_W-1:0];
        next_addr = cur_reg[ENT_W-1:0];
        used_addr = scan_reg;
        head_addr = {bank_reg, bucket_reg};
        tail_addr = rem_bkt;
        next_wd   = EMPTY_MARK;
        head_wd   = EMPTY_MARK;
        tail_wd   = EMPTY_MARK;
        used_wd   = 1'b0;
        case (cmd.cmd)
            CMD_CLR: begin
                head_we   = 1'b1;
                head_addr = {bank_reg, clr_reg};
                used_we   = (BCNT_W'(clr_reg) < BCNT_W'(MAX_ENTRIES));
                used_addr = clr_reg[ENT_W-1:0];
            end
            CMD_HEAD_RD: begin
                head_addr = {bank_reg, rem_bkt};
            end
            CMD_DEL: begin
                used_we   = 1'b1;
                used_addr = cur_reg[ENT_W-1:0];
                if (prev_reg == EMPTY_MARK) begin
                    head_we = 1'b1;
                    head_wd = nxt_reg;
                end else begin
                    next_we   = 1'b1;
                    next_addr = prev_reg[ENT_W-1:0];
                    next_wd   = nxt_reg;
                end
            end
            CMD_INS_WR: begin
                key_we    = 1'b1;
                next_we   = 1'b1;
                used_we   = 1'b1;
                used_wd   = 1'b1;
                key_addr  = scan_reg;
                next_addr = scan_reg;
            end
            CMD_INS_LINK: begin
                if (prev_reg == EMPTY_MARK) begin
                    head_we = 1'b1;
                    head_wd = {1'b0, scan_reg};
                end else begin
                    next_we   = 1'b1;
                    next_addr = prev_reg[ENT_W-1:0];
                    next_wd   = {1'b0, scan_reg};
                end
            end
            CMD_RH_CLR: begin
                head_we   = 1'b1;
                head_addr = {~bank_reg, clr_reg};
                tail_we   = 1'b1;
                tail_addr = clr_reg;
            end
            CMD_RH_HEAD_RD: begin
                head_addr = {bank_reg, rb_reg};
            end
            CMD_RH_TAIL_RD: begin
                next_we = 1'b1;
            end
            CMD_RH_LINK: begin
                tail_we = 1'b1;
                tail_wd = cur_reg;
                if (tl_reg == EMPTY_MARK) begin
                    head_we   = 1'b1;
                    head_addr = {~bank_reg, rem_bkt};
                    head_wd   = cur_reg;
                end else begin
                    next_we   = 1'b1;
                    next_addr = tl_reg[ENT_W-1:0];
                    next_wd   = cur_reg;
                end
            end
            default: begin
            end
        endcase
    end

    chtr_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_keys (
        .aclk(aclk), .we(key_we), .addr(key_addr), .wr_data(key_reg), .rd_data(key_rd)
    );

    chtr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_vals (
        .aclk(aclk), .we(key_we), .addr(key_addr), .wr_data(val_reg), .rd_data()
    );

    chtr_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ENTRIES)) u_next (
        .aclk(aclk), .we(next_we), .addr(next_addr), .wr_data(next_wd), .rd_data(next_rd)
    );

    chtr_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_used (
        .aclk(aclk), .we(used_we), .addr(used_addr), .wr_data(used_wd), .rd_data(used_rd)
    );

    chtr_ram #(.WIDTH(NODE_W), .DEPTH(2 * MAX_BUCKETS)) u_heads (
        .aclk(aclk), .we(head_we), .addr(head_addr), .wr_data(head_wd), .rd_data(head_rd)
    );

    chtr_ram #(.WIDTH(NODE_W), .DEPTH(MAX_BUCKETS)) u_tails (
        .aclk(aclk), .we(tail_we), .addr(tail_addr), .wr_data(tail_wd), .rd_data(tail_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg    <= INIT_RESET;
            bank_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                init_reg <= cfg_wr_data;
            end
            if (cmd.cmd == CMD_RESULT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.cmd == CMD_RH_FINISH) begin
                bank_reg <= ~bank_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.cmd)
            CMD_CLR_INIT: begin
                clr_reg   <= '0;
                pairs_reg <= '0;
                bnow_reg  <= init_clamped;
            end
            CMD_CLR, CMD_RH_CLR: begin
                clr_reg <= clr_reg + BKT_W'(1);
            end
            CMD_ACCEPT: begin
                op_reg   <= s_op;
                key_reg  <= s_key;
                val_reg  <= s_value;
                dvd_reg  <= s_key;
                dsr_reg  <= bnow_reg;
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            CMD_DIV_STEP: begin
                rem_reg  <= rem_sub[BCNT_W-1:0];
                dvd_reg  <= {dvd_reg[KEY_W-2:0], 1'b0};
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end
            CMD_HEAD_RD: begin
                bucket_reg <= rem_bkt;
            end
            CMD_HEAD_LD: begin
                cur_reg   <= head_rd;
                prev_reg  <= EMPTY_MARK;
                found_reg <= 1'b0;
            end
            CMD_NODE_LD: begin
                nxt_reg <= next_rd;
                if (key_rd == key_reg) begin
                    found_reg <= 1'b1;
                end else begin
                    prev_reg <= cur_reg;
                    cur_reg  <= next_rd;
                end
            end
            CMD_DEL: begin
                pairs_reg <= pairs_reg - CNT_W'(1);
            end
            CMD_SCAN_INIT: begin
                scan_reg <= '0;
            end
            CMD_SCAN_NEXT: begin
                scan_reg <= scan_reg + ENT_W'(1);
            end
            CMD_INS_WR: begin
                pairs_reg <= pairs_reg + CNT_W'(1);
            end
            CMD_RH_INIT: begin
                grown_reg <= grown;
                clr_reg   <= '0;
                rb_reg    <= '0;
            end
            CMD_RH_HEAD_LD: begin
                cur_reg <= head_rd;
            end
            CMD_RH_NODE_LD: begin
                nxt_reg  <= next_rd;
                dvd_reg  <= key_rd;
                dsr_reg  <= grown_reg;
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            CMD_RH_TAIL_LD: begin
                tl_reg <= tail_rd;
            end
            CMD_RH_LINK: begin
                cur_reg <= nxt_reg;
            end
            CMD_RH_NEXT_BKT: begin
                rb_reg <= rb_reg + BKT_W'(1);
            end
            CMD_RH_FINISH: begin
                bnow_reg <= grown_reg;
            end
            CMD_RESULT: begin
                m_found_reg  <= found_reg;
                m_status_reg <= cmd.status;
                m_bcnt_reg   <= bnow_reg;
                m_ecnt_reg   <= pairs_reg;
            end
            default: begin
            end
        endcase
    end

    assign sts.cur_empty  = (cur_reg >= EMPTY_MARK);
    assign sts.key_match  = (key_rd == key_reg);
    assign sts.used_bit   = used_rd;
    assign sts.div_last   = (dcnt_reg == DCNT_W'(KEY_W - 1));
    assign sts.clr_last   = (clr_reg == BKT_W'(MAX_BUCKETS - 1));
    assign sts.rb_last    = ((BCNT_W'(rb_reg) + BCNT_W'(1)) == bnow_reg);
    assign sts.pairs_full = (pairs_reg >= CNT_W'(MAX_ENTRIES));
    assign sts.need_grow  = (BCNT_W'(pairs_reg) > bnow_reg);
    assign sts.can_grow   = (bnow_reg < BCNT_W'(MAX_BUCKETS));
    assign sts.out_busy   = m_valid_reg;
    assign sts.found      = found_reg;
    assign sts.op         = op_reg;

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_status       = m_status_reg;
    assign m_bucket_count = m_bcnt_reg;
    assign m_entry_count  = m_ecnt_reg;

endmodule

@@ rtl/chtr_ctrl.sv @@
// chtr_ctrl: sequencer for clearing, lookup, insert, delete and rehash
// drives datapath commands from status; uses chtr_pkg
module chtr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  m_ready,
    input  chtr_pkg::dp_status_t  sts,
    output chtr_pkg::dp_cmd_t     cmd
);
    import chtr_pkg::*;

    typedef enum logic [4:0] {
        S_CLR_INIT, S_CLR, S_IDLE, S_DIV, S_HEAD_RD, S_HEAD_LD, S_NODE_CHK,
        S_NODE_LD, S_DECIDE, S_DEL, S_SCAN_RD, S_SCAN_CHK, S_INS_WR,
        S_INS_LINK, S_RH_INIT, S_RH_CLR, S_RH_HEAD_RD, S_RH_HEAD_LD,
        S_RH_NODE_CHK, S_RH_NODE_LD, S_RH_DIV, S_RH_TAIL_RD, S_RH_TAIL_LD,
        S_RH_LINK, S_RH_FINISH, S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [ST_W-1:0] res_reg, res_next;

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd.cmd    = CMD_NOP;
        cmd.status = res_reg;
        case (state_reg)
            S_CLR_INIT: begin
                cmd.cmd    = CMD_CLR_INIT;
                state_next = S_CLR;
            end
            S_CLR: begin
                cmd.cmd = CMD_CLR;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.cmd    = CMD_ACCEPT;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.cmd = CMD_DIV_STEP;
                if (sts.div_last) begin
                    state_next = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                cmd.cmd    = CMD_HEAD_RD;
                state_next = S_HEAD_LD;
            end
            S_HEAD_LD: begin
                cmd.cmd    = CMD_HEAD_LD;
                state_next = S_NODE_CHK;
            end
            S_NODE_CHK: begin
                if (sts.cur_empty) begin
                    state_next = S_DECIDE;
                end else begin
                    cmd.cmd    = CMD_NODE_RD;
                    state_next = S_NODE_LD;
                end
            end
            S_NODE_LD: begin
                cmd.cmd    = CMD_NODE_LD;
                state_next = sts.key_match ? S_DECIDE : S_NODE_CHK;
            end
            S_DECIDE: begin
                state_next = S_DONE;
                case (sts.op)
                    OP_INSERT: begin
                        if (sts.found) begin
                            res_next = ST_PRESENT;
                        end else if (sts.pairs_full) begin
                            res_next = ST_FULL;
                        end else begin
                            res_next   = ST_DONE;
                            cmd.cmd    = CMD_SCAN_INIT;
                            state_next = S_SCAN_RD;
                        end
                    end
                    OP_DELETE: begin
                        if (sts.found) begin
                            res_next   = ST_DONE;
                            state_next = S_DEL;
                        end else begin
                            res_next = ST_ABSENT;
                        end
                    end
                    default: begin
                        res_next = sts.found ? ST_DONE : ST_ABSENT;
                    end
                endcase
            end
            S_DEL: begin
                cmd.cmd    = CMD_DEL;
                state_next = S_DONE;
            end
            S_SCAN_RD: begin
                cmd.cmd    = CMD_SCAN_RD;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (sts.used_bit) begin
                    cmd.cmd    = CMD_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end else begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR: begin
                cmd.cmd    = CMD_INS_WR;
                state_next = S_INS_LINK;
            end
            S_INS_LINK: begin
                cmd.cmd    = CMD_INS_LINK;
                state_next = (sts.need_grow && sts.can_grow) ? S_RH_INIT : S_DONE;
            end
            S_RH_INIT: begin
                cmd.cmd    = CMD_RH_INIT;
                state_next = S_RH_CLR;
            end
            S_RH_CLR: begin
                cmd.cmd = CMD_RH_CLR;
                if (sts.clr_last) begin
                    state_next = S_RH_HEAD_RD;
                end
            end
            S_RH_HEAD_RD: begin
                cmd.cmd    = CMD_RH_HEAD_RD;
                state_next = S_RH_HEAD_LD;
            end
            S_RH_HEAD_LD: begin
                cmd.cmd    = CMD_RH_HEAD_LD;
                state_next = S_RH_NODE_CHK;
            end
            S_RH_NODE_CHK: begin
                if (!sts.cur_empty) begin
                    cmd.cmd    = CMD_RH_NODE_RD;
                    state_next = S_RH_NODE_LD;
                end else if (sts.rb_last) begin
                    state_next = S_RH_FINISH;
                end else begin
                    cmd.cmd    = CMD_RH_NEXT_BKT;
                    state_next = S_RH_HEAD_RD;
                end
            end
            S_RH_NODE_LD: begin
                cmd.cmd    = CMD_RH_NODE_LD;
                state_next = S_RH_DIV;
            end
            S_RH_DIV: begin
                cmd.cmd = CMD_DIV_STEP;
                if (sts.div_last) begin
                    state_next = S_RH_TAIL_RD;
                end
            end
            S_RH_TAIL_RD: begin
                cmd.cmd    = CMD_RH_TAIL_RD;
                state_next = S_RH_TAIL_LD;
            end
            S_RH_TAIL_LD: begin
                cmd.cmd    = CMD_RH_TAIL_LD;
                state_next = S_RH_LINK;
            end
            S_RH_LINK: begin
                cmd.cmd    = CMD_RH_LINK;
                state_next = S_RH_NODE_CHK;
            end
            S_RH_FINISH: begin
                cmd.cmd    = CMD_RH_FINISH;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!sts.out_busy || m_ready) begin
                    cmd.cmd    = CMD_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLR_INIT;
            end
        endcase
        if (cfg_wr_en) begin
            state_next = S_CLR_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR_INIT;
            res_reg   <= ST_DONE;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking testbench for chained_hash_table_rehash
// predicts found/status/bucket/entry counts from a key set model; uses chtr_pkg
`timescale 1ns / 1ps

module tb_top;
    import chtr_pkg::*;

    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

    typedef struct {
        logic              found;
        logic [ST_W-1:0]   status;
        logic [BCNT_W-1:0] buckets;
        logic [CNT_W-1:0]  entries;
    } lookup_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [INIT_W-1:0] cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [OP_W-1:0]   s_op = '0;
    logic [KEY_W-1:0]  s_key = '0;
    logic [VAL_W-1:0]  s_value = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_found;
    logic [ST_W-1:0]   m_status;
    logic [BCNT_W-1:0] m_bucket_count;
    logic [CNT_W-1:0]  m_entry_count;

    chained_hash_table_rehash u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_key         (s_key),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_status      (m_status),
        .m_bucket_count(m_bucket_count),
        .m_entry_count (m_entry_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // table model: only key presence and the counts are visible
    bit               stored_keys [bit [KEY_W-1:0]];
    int unsigned      bucket_total;
    int unsigned      pair_total;
    bit [KEY_W-1:0]   recent_keys[$];
    lookup_result_t   pending_results[$];
    int               error_count = 0;
    int               burst_left = 0;
    bit               gaps_on = 1'b1;

    function automatic void clear_table(input logic [INIT_W-1:0] init_val);
        stored_keys.delete();
        pair_total = 0;
        bucket_total = (init_val == 0) ? 1 : ((init_val > MAX_BUCKETS) ? MAX_BUCKETS : init_val);
    endfunction

    function automatic lookup_result_t apply_request(input logic [OP_W-1:0] op,
                                                     input logic [KEY_W-1:0] key);
        lookup_result_t r;
        int unsigned grown;
        r.found = stored_keys.exists(key);
        if (op == OP_INSERT) begin
            if (r.found) begin
                r.status = ST_PRESENT;
            end else if (pair_total >= MAX_ENTRIES) begin
                r.status = ST_FULL;
            end else begin
                stored_keys[key] = 1'b1;
                pair_total++;
                if (pair_total > bucket_total) begin
                    grown = bucket_total * 2;
                    if (grown > MAX_BUCKETS) grown = MAX_BUCKETS;
                    bucket_total = grown;
                end
                r.status = ST_DONE;
            end
        end else if (op == OP_DELETE) begin
            if (r.found) begin
                stored_keys.delete(key);
                pair_total--;
                r.status = ST_DONE;
            end else begin
                r.status = ST_ABSENT;
            end
        end else begin
            r.status = r.found ? ST_DONE : ST_ABSENT;
        end
        r.buckets = BCNT_W'(bucket_total);
        r.entries = CNT_W'(pair_total);
        return r;
    endfunction

    task automatic send_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20)) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_op    <= op;
        s_key   <= key;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.insert(pending_results.size(), apply_request(op, key));
        if (op == OP_INSERT) begin
            recent_keys.insert(recent_keys.size(), key);
            if (recent_keys.size() > 64) void'(recent_keys.pop_front());
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_buckets(input logic [INIT_W-1:0] init_val);
        wait_drained();
        repeat (20) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= init_val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        clear_table(init_val);
        recent_keys.delete();
    endtask

    // receiver stall pattern, re-chosen every so often
    int rcv_mode = 0;
    int rcv_left = 0;
    int rcv_phase = 0;
    always @(posedge aclk) begin
        if (rcv_left == 0) begin
            rcv_mode <= $urandom_range(0, 3);
            rcv_left <= $urandom_range(20, 300);
        end else begin
            rcv_left <= rcv_left - 1;
        end
        rcv_phase <= rcv_phase + 1;
        case (rcv_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= rcv_phase[0];
            2: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= (rcv_phase % 16) > 11;
        endcase
    end

    always @(posedge aclk) begin
        lookup_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                error_count++;
            end else begin
                e = pending_results.pop_front();
                if (m_found !== e.found) begin
                    $error("found: expected %0d actual %0d", e.found, m_found);
                    error_count++;
                end
                if (m_status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, m_status);
                    error_count++;
                end
                if (m_bucket_count !== e.buckets) begin
                    $error("bucket_count: expected %0d actual %0d", e.buckets, m_bucket_count);
                    error_count++;
                end
                if (m_entry_count !== e.entries) begin
                    $error("entry_count: expected %0d actual %0d", e.entries, m_entry_count);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2: return KEY_W'($urandom_range(0, 255));
            3, 4, 5, 6: begin
                if (recent_keys.size() != 0)
                    return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                return KEY_W'($urandom_range(0, 63));
            end
            7: return {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 15));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        case ($urandom_range(0, 19))
            0: return OP_SPARE;
            1, 2, 3, 4: return OP_SEARCH;
            5, 6, 7, 8, 9, 10, 11, 12, 13: return OP_INSERT;
            default: return OP_DELETE;
        endcase
    endfunction

    task automatic test_basic_ops();
        write_buckets(INIT_W'(0));
        send_req(OP_INSERT, '0, 32'h8000_0000);
        send_req(OP_INSERT, {KEY_W{1'b1}}, 32'h7fff_ffff);
        send_req(OP_SEARCH, '0, '0);
        send_req(OP_SEARCH, {KEY_W{1'b1}}, 32'hffff_ffff);
        send_req(OP_SEARCH, KEY_W'(5), '0);
        send_req(OP_INSERT, '0, 32'h1234_5678);
        send_req(OP_DELETE, KEY_W'(5), '0);
        send_req(OP_SPARE, '0, '0);
        send_req(OP_SPARE, KEY_W'(9), '0);
        send_req(OP_INSERT, KEY_W'(2), 32'h5555_5555);
        send_req(OP_INSERT, KEY_W'(3), 32'haaaa_aaaa);
        send_req(OP_DELETE, '0, '0);
        send_req(OP_SEARCH, '0, '0);
        send_req(OP_DELETE, {KEY_W{1'b1}}, '0);
        send_req(OP_INSERT, KEY_W'(7), '0);
        send_req(OP_INSERT, KEY_W'(11), '1);
        send_req(OP_SEARCH, KEY_W'(11), '0);
        write_buckets(INIT_W'(2047));
        send_req(OP_INSERT, KEY_W'(2047), 32'h0000_0001);
        send_req(OP_INSERT, KEY_W'(4094), 32'h0000_0002);
        send_req(OP_SEARCH, KEY_W'(4094), '0);
        send_req(OP_DELETE, KEY_W'(2047), '0);
    endtask

    task automatic test_store_full();
        write_buckets(INIT_W'(1));
        gaps_on = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++)
            send_req(OP_INSERT, KEY_W'(i * 3 + 7), $urandom);
        send_req(OP_INSERT, KEY_W'(2), $urandom);
        send_req(OP_INSERT, KEY_W'(10), $urandom);
        send_req(OP_DELETE, KEY_W'(100), '0);
        send_req(OP_INSERT, KEY_W'(2), $urandom);
        send_req(OP_SEARCH, KEY_W'(2), '0);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [INIT_W-1:0] settings[4];
        settings[0] = INIT_W'($urandom_range(1, 64));
        settings[1] = INIT_W'(1);
        settings[2] = INIT_W'($urandom);
        settings[3] = INIT_W'(16);
        foreach (settings[p]) begin
            write_buckets(settings[p]);
            for (int i = 0; i < 50; i++) begin
                if (p == 1 && i == 25) wait_drained();
                send_req(pick_op(), pick_key(), $urandom);
            end
        end
    endtask

    initial begin
        clear_table(INIT_RESET);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_ops();
        test_store_full();
        test_random_traffic();
        wait_drained();
        repeat (50) @(posedge aclk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/chtr_pkg.sv
rtl/chtr_ram.sv
rtl/chtr_dp.sv
rtl/chtr_ctrl.sv
rtl/chained_hash_table_rehash.sv
dv/tb_top.sv
